// ===== hw/rtl/qclf_pkg.sv =====
// Shared constants and types for the quoted command line framer.
package qclf_pkg;

    localparam int BUF_DEPTH_DEF = 64;
    localparam int LEN_W         = 6;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_OVF  = 1'b1;

    typedef struct packed {
        logic             is_ovf;
        logic             bank;
        logic [LEN_W-1:0] len;
    } qclf_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_RUN  = 2'b10
    } qclf_back_state_t;

endpackage

// ===== hw/rtl/qclf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module qclf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/qclf_cmdq.sv =====
// Two-entry command queue between the front and back parts.
module qclf_cmdq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  qclf_pkg::qclf_cmd_t push_cmd,
    input  logic                pop,
    output qclf_pkg::qclf_cmd_t head,
    output logic                empty,
    output logic                full
);
    import qclf_pkg::*;

    qclf_cmd_t   entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/qclf_front.sv =====
// Front part: accept and classify bytes, fill the line store, queue commands.
module qclf_front #(
    parameter int BUF_DEPTH = qclf_pkg::BUF_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [7:0]                     rx_byte,
    output logic                           busy,
    input  logic                           q_full,
    input  logic                           drain_done,
    output logic                           q_push,
    output qclf_pkg::qclf_cmd_t            q_cmd,
    output logic                           wr_en,
    output logic [$clog2(BUF_DEPTH):0]     wr_addr,
    output logic [7:0]                     wr_data
);
    import qclf_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    logic [AW-1:0] fill_reg, fill_next;
    logic          quote_reg, quote_next;
    logic          bank_reg, bank_next;
    logic [1:0]    drains_reg, drains_next;
    logic          accept, is_quote, is_delim, is_full;
    logic [AW:0]   fill_inc;

    assign busy     = q_full || (drains_reg == 2'd2);
    assign accept   = start && !busy;
    assign is_quote = (rx_byte == CH_QUOTE);
    assign is_delim = (rx_byte == CH_LF) || (rx_byte == CH_CR) ||
                      ((rx_byte == CH_SEMI) && !quote_reg);
    assign fill_inc = {1'b0, fill_reg} + {{AW{1'b0}}, 1'b1};
    assign is_full  = (fill_inc == (AW + 1)'(BUF_DEPTH));

    assign wr_en   = accept && !is_quote && !is_delim;
    assign wr_addr = {bank_reg, fill_reg};
    assign wr_data = rx_byte;

    always_comb
    begin
        fill_next    = fill_reg;
        quote_next   = quote_reg;
        bank_next    = bank_reg;
        q_push       = 1'b0;
        q_cmd.is_ovf = 1'b0;
        q_cmd.bank   = bank_reg;
        q_cmd.len    = LEN_W'(fill_reg);
        if (accept)
        begin
            priority if (is_quote)
            begin
                quote_next = !quote_reg;
            end
            else if (is_delim)
            begin
                quote_next = 1'b0;
                fill_next  = '0;
                if (fill_reg != '0)
                begin
                    q_push    = 1'b1;
                    bank_next = !bank_reg;
                end
            end
            else if (is_full)
            begin
                fill_next    = '0;
                q_push       = 1'b1;
                q_cmd.is_ovf = 1'b1;
            end
            else
            begin
                fill_next = fill_inc[AW-1:0];
            end
        end
        drains_next = drains_reg + {1'b0, q_push && !q_cmd.is_ovf} - {1'b0, drain_done};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            quote_reg  <= 1'b0;
            bank_reg   <= 1'b0;
            drains_reg <= 2'd0;
        end
        else
        begin
            fill_reg   <= fill_next;
            quote_reg  <= quote_next;
            bank_reg   <= bank_next;
            drains_reg <= drains_next;
        end
    end

endmodule

// ===== hw/rtl/qclf_back.sv =====
// Back part: pop commands, read out stored lines, drive the result ports.
module qclf_back #(
    parameter int BUF_DEPTH = qclf_pkg::BUF_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  qclf_pkg::qclf_cmd_t            q_head,
    output logic                           q_pop,
    output logic                           drain_done,
    output logic                           rd_en,
    output logic [$clog2(BUF_DEPTH):0]     rd_addr,
    input  logic [7:0]                     rd_data,
    output logic                           strobe,
    output logic                           kind,
    output logic [7:0]                     cmd_byte,
    output logic                           last
);
    import qclf_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    qclf_back_state_t state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    len_reg, len_next;
    logic             bank_reg, bank_next;
    logic             vld_reg, vld_next;
    logic             kind_reg, kind_next;
    logic             last_reg, last_next;
    logic             at_end;

    assign at_end  = (idx_reg == len_reg - {{(AW-1){1'b0}}, 1'b1});
    assign rd_addr = {bank_reg, idx_reg};

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        bank_next  = bank_reg;
        vld_next   = 1'b0;
        kind_next  = kind_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        drain_done = 1'b0;
        rd_en      = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.is_ovf)
                    begin
                        vld_next  = 1'b1;
                        kind_next = KIND_OVF;
                        last_next = 1'b1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        len_next   = q_head.len[AW-1:0];
                        bank_next  = q_head.bank;
                        state_next = BK_RUN;
                    end
                end
            end
            BK_RUN:
            begin
                rd_en     = 1'b1;
                vld_next  = 1'b1;
                kind_next = KIND_BYTE;
                last_next = at_end;
                idx_next  = idx_reg + {{(AW-1){1'b0}}, 1'b1};
                if (at_end)
                begin
                    drain_done = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        bank_reg <= bank_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign strobe   = vld_reg;
    assign kind     = kind_reg;
    assign last     = last_reg;
    assign cmd_byte = (kind_reg == KIND_OVF) ? 8'd0 : rd_data;

endmodule

// ===== hw/rtl/quoted_command_line_framer_core.sv =====
// Quoted command line framer top level: front, command queue, line store, back.
// With the back part idle, a line's first byte strobes after its delimiter passes the
// command queue, run state and read register; an overflow result skips the run state.
// Throughput: one byte per cycle while filling and busy is low; the back part pops each
// queued command in an idle state first; the receiver cannot stall results.
// busy rises while two lines await readout or the command queue is full; reset clears
// counts, quote mode and queue, the line store keeps its contents.
module quoted_command_line_framer_core #(
    parameter int BUF_DEPTH = qclf_pkg::BUF_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] rx_byte,
    output logic       strobe,
    output logic       kind,
    output logic [7:0] cmd_byte,
    output logic       last
);
    import qclf_pkg::*;

    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int RAM_DEPTH = 2 * (2 ** AW);

    logic          q_push, q_pop, q_empty, q_full, drain_done;
    qclf_cmd_t     q_cmd, q_head;
    logic          wr_en, rd_en;
    logic [AW:0]   wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    qclf_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .rx_byte    (rx_byte),
        .busy       (busy),
        .q_full     (q_full),
        .drain_done (drain_done),
        .q_push     (q_push),
        .q_cmd      (q_cmd),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    qclf_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    qclf_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    qclf_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .drain_done (drain_done),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .strobe     (strobe),
        .kind       (kind),
        .cmd_byte   (cmd_byte),
        .last       (last)
    );

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> busy)
        else $error("queue full without busy");

    a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind == KIND_OVF) |-> (last && cmd_byte == 8'd0))
        else $error("malformed overflow item");

    a_line_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> (strobe && kind == KIND_BYTE))
        else $error("gap inside a command line");

endmodule

// ===== tb/qclf_checker.sv =====
// Checker for the quoted command line framer: predicts each item's results and compares them.
`timescale 1ns / 1ps

module qclf_checker #(
    parameter int BUF_DEPTH = qclf_pkg::BUF_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [7:0] rx_byte,
    input  logic       strobe,
    input  logic       kind,
    input  logic [7:0] cmd_byte,
    input  logic       last,
    output int         errors,
    output int         pending,
    output int         lines_seen,
    output int         overflows_seen
);
    import qclf_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } line_beat_t;

    line_beat_t  expected_beats[$];
    logic [7:0]  line_copy [BUF_DEPTH];
    int unsigned held_bytes;
    logic        quoted;

    task automatic frame_byte(input logic [7:0] b);
        int unsigned n;
        line_beat_t  beat;
        n = held_bytes;
        if (b == CH_QUOTE)
        begin
            quoted = ~quoted;
        end
        else if (b == CH_LF || b == CH_CR || (b == CH_SEMI && !quoted))
        begin
            quoted = 1'b0;
            if (n > BUF_DEPTH - 1)
                n = BUF_DEPTH - 1;
            for (int unsigned i = 0; i < n; i++)
            begin
                beat.kind = KIND_BYTE;
                beat.data = line_copy[i];
                beat.last = (i + 1 == n);
                expected_beats.push_back(beat);
            end
            held_bytes = 0;
        end
        else
        begin
            if (n < BUF_DEPTH)
            begin
                line_copy[n] = b;
                n++;
            end
            if (n >= BUF_DEPTH)
            begin
                beat.kind = KIND_OVF;
                beat.data = 8'd0;
                beat.last = 1'b1;
                expected_beats.push_back(beat);
                held_bytes = 0;
            end
            else
            begin
                held_bytes = n;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_beat_t want;
        if (!rst_n)
        begin
            expected_beats.delete();
            held_bytes     = 0;
            quoted         = 1'b0;
            pending        = 0;
            errors         = 0;
            lines_seen     = 0;
            overflows_seen = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (expected_beats.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result kind=%0b cmd_byte=%02h last=%0b",
                             $time, kind, cmd_byte, last);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (kind !== want.kind)
                    begin
                        errors++;
                        $display("%0t: kind mismatch expected %0b actual %0b",
                                 $time, want.kind, kind);
                    end
                    if (cmd_byte !== want.data)
                    begin
                        errors++;
                        $display("%0t: cmd_byte mismatch expected %02h actual %02h",
                                 $time, want.data, cmd_byte);
                    end
                    if (last !== want.last)
                    begin
                        errors++;
                        $display("%0t: last mismatch expected %0b actual %0b",
                                 $time, want.last, last);
                    end
                    if (want.kind == KIND_OVF)
                        overflows_seen++;
                    else if (want.last)
                        lines_seen++;
                end
            end
            if (start && !busy)
                frame_byte(rx_byte);
            pending = expected_beats.size();
        end
    end

endmodule

// ===== tb/tb_quoted_command_line_framer_core.sv =====
// Testbench top for the quoted command line framer: drives bytes and reports the verdict.
`timescale 1ns / 1ps

module tb_quoted_command_line_framer_core;
    import qclf_pkg::*;

    localparam int BUF_DEPTH   = BUF_DEPTH_DEF;
    localparam int TOTAL_BYTES = 230;
    localparam int CALM_AFTER  = 190;

    localparam logic [7:0] DIRECTED_SEQ [21] = '{
        CH_LF, CH_QUOTE, CH_SEMI, 8'h00, 8'hFF, CH_QUOTE, CH_SEMI,
        8'h41, CH_QUOTE, 8'h7F, CH_CR, CH_SEMI, CH_QUOTE, CH_QUOTE,
        8'h80, CH_LF, CH_QUOTE, CH_LF, CH_SEMI, 8'h01, CH_CR
    };

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [7:0] rx_byte;
    logic       strobe;
    logic       kind;
    logic [7:0] cmd_byte;
    logic       last;

    int errors;
    int pending;
    int lines_seen;
    int overflows_seen;
    int bytes_sent;
    bit gaps_on;

    quoted_command_line_framer_core #(
        .BUF_DEPTH(BUF_DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .rx_byte (rx_byte),
        .strobe  (strobe),
        .kind    (kind),
        .cmd_byte(cmd_byte),
        .last    (last)
    );

    qclf_checker #(
        .BUF_DEPTH(BUF_DEPTH)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .rx_byte       (rx_byte),
        .strobe        (strobe),
        .kind          (kind),
        .cmd_byte      (cmd_byte),
        .last          (last),
        .errors        (errors),
        .pending       (pending),
        .lines_seen    (lines_seen),
        .overflows_seen(overflows_seen)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("quoted_command_line_framer_core verification failed");
        $finish;
    end

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_LF || b == CH_CR || b == CH_SEMI || b == CH_QUOTE)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            start   <= 1'b0;
            rx_byte <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line(input int len);
        bit in_q;
        int pick;
        in_q = 1'b0;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_byte(CH_QUOTE);
                in_q = ~in_q;
            end
            if (in_q && $urandom_range(0, 3) == 0)
                send_byte(CH_SEMI);
            else
                send_byte(plain_byte());
        end
        pick = $urandom_range(0, 2);
        if (pick == 0)
        begin
            if (in_q)
                send_byte(CH_QUOTE);
            send_byte(CH_SEMI);
        end
        else
        begin
            send_byte(pick == 1 ? CH_LF : CH_CR);
        end
    endtask

    initial
    begin
        int sel;
        int noise_len;
        rst_n      = 1'b0;
        start      = 1'b0;
        rx_byte    = 8'd0;
        bytes_sent = 0;
        gaps_on    = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_SEQ[i])
            send_byte(DIRECTED_SEQ[i]);

        while (bytes_sent < TOTAL_BYTES)
        begin
            gaps_on = (bytes_sent < CALM_AFTER);
            sel = $urandom_range(0, 15);
            if (sel == 0)
                send_line(BUF_DEPTH - 1);
            else if (sel == 1)
                send_line(BUF_DEPTH);
            else if (sel <= 4)
                send_line($urandom_range(10, BUF_DEPTH - 2));
            else if (sel <= 6)
            begin
                noise_len = $urandom_range(1, 6);
                repeat (noise_len) send_byte(8'($urandom_range(0, 255)));
            end
            else
                send_line($urandom_range(0, 8));
        end
        start <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes; checked %0d command lines and %0d overflow results.",
                 bytes_sent, lines_seen, overflows_seen);
        if (errors == 0 && pending == 0)
            $display("quoted_command_line_framer_core verification clean");
        else
            $display("quoted_command_line_framer_core verification failed");
        $finish;
    end

endmodule
